// ===== sv/b64e_pkg.sv =====
`default_nettype none

package b64e_pkg;

	localparam int unsigned LINE_CHARS = 76;
	localparam int unsigned MAX_CHARS  = 6;

	localparam logic [6:0] LINE_LIMIT = 7'(LINE_CHARS);

	localparam logic [1:0] MODE_STD  = 2'd0;
	localparam logic [1:0] MODE_MIME = 2'd1;
	localparam logic [1:0] MODE_URL  = 2'd2;

	localparam logic [7:0] CHAR_PAD = 8'h3d;
	localparam logic [7:0] CHAR_CR  = 8'h0d;
	localparam logic [7:0] CHAR_LF  = 8'h0a;

	typedef struct packed {
		logic [MAX_CHARS-1:0][7:0] chars;
		logic [2:0]                count;
		logic                      fin;
	} burst_t;

	function automatic logic [7:0] sextet(input logic [5:0] v, input logic url);
		logic [7:0] c;
		if (v < 6'd26) begin
			c = 8'h41 + 8'(v);
		end else if (v < 6'd52) begin
			c = 8'h61 + 8'(v - 6'd26);
		end else if (v < 6'd62) begin
			c = 8'h30 + 8'(v - 6'd52);
		end else if (v == 6'd62) begin
			c = url ? 8'h2d : 8'h2b;
		end else begin
			c = url ? 8'h5f : 8'h2f;
		end
		return c;
	endfunction

endpackage

`default_nettype wire

// ===== sv/b64e_group_enc.sv =====
`default_nettype none

module b64e_group_enc import b64e_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic [1:0] mode,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] data_byte,
	input  wire logic       final_byte,
	output logic            burst_valid,
	output burst_t          burst,
	input  wire logic       burst_take
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       fin_s1;

	logic [1:0] pos_q;
	logic [3:0] carry_q;
	logic [6:0] line_q;

	logic [1:0] pos_n;
	logic [3:0] carry_n;
	logic [6:0] line_n;
	logic [6:0] line_base;
	logic [MAX_CHARS-1:0][7:0] slots;
	logic [2:0] n;
	logic       url;
	logic       pad;
	logic       mime;

	assign in_ready    = !valid_s1 || burst_take;
	assign burst_valid = valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (burst_take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= data_byte;
			fin_s1  <= final_byte;
		end
	end

	always_comb begin
		url       = (mode == MODE_URL);
		pad       = !url;
		mime      = (mode == MODE_MIME);
		n         = 3'd0;
		slots     = '0;
		pos_n     = pos_q;
		carry_n   = carry_q;
		line_n    = line_q;
		line_base = line_q;
		case (pos_q)
			2'd0: begin
				if (mime) begin
					if (line_q >= LINE_LIMIT) begin
						slots[n] = CHAR_CR;
						n = n + 3'd1;
						slots[n] = CHAR_LF;
						n = n + 3'd1;
						line_base = 7'd0;
					end
					line_n = line_base + 7'd4;
				end
				slots[n] = sextet(byte_s1[7:2], url);
				n = n + 3'd1;
				carry_n = {2'b00, byte_s1[1:0]};
				pos_n   = 2'd1;
				if (fin_s1) begin
					slots[n] = sextet({byte_s1[1:0], 4'b0000}, url);
					n = n + 3'd1;
					if (pad) begin
						slots[n] = CHAR_PAD;
						n = n + 3'd1;
						slots[n] = CHAR_PAD;
						n = n + 3'd1;
					end
				end
			end
			2'd1: begin
				slots[n] = sextet({carry_q[1:0], byte_s1[7:4]}, url);
				n = n + 3'd1;
				carry_n = byte_s1[3:0];
				pos_n   = 2'd2;
				if (fin_s1) begin
					slots[n] = sextet({byte_s1[3:0], 2'b00}, url);
					n = n + 3'd1;
					if (pad) begin
						slots[n] = CHAR_PAD;
						n = n + 3'd1;
					end
				end
			end
			default: begin
				slots[n] = sextet({carry_q, byte_s1[7:6]}, url);
				n = n + 3'd1;
				slots[n] = sextet(byte_s1[5:0], url);
				n = n + 3'd1;
				carry_n = 4'd0;
				pos_n   = 2'd0;
			end
		endcase
		if (fin_s1) begin
			pos_n   = 2'd0;
			carry_n = 4'd0;
			line_n  = 7'd0;
		end
	end

	assign burst.chars = slots;
	assign burst.count = n;
	assign burst.fin   = fin_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= 2'd0;
			carry_q <= 4'd0;
			line_q  <= 7'd0;
		end else if (burst_take) begin
			pos_q   <= pos_n;
			carry_q <= carry_n;
			line_q  <= line_n;
		end
	end

endmodule

`default_nettype wire

// ===== sv/b64e_char_buf.sv =====
`default_nettype none

module b64e_char_buf import b64e_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       burst_valid,
	input  wire burst_t     burst,
	output logic            burst_take,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      out_char,
	output logic            run_last,
	output logic            text_end
);

	logic [MAX_CHARS-1:0][7:0] chars_q;
	logic [2:0]                rem_q;
	logic                      fin_q;

	assign out_valid  = (rem_q != 3'd0);
	assign run_last   = (rem_q == 3'd1);
	assign text_end   = run_last && fin_q;
	assign out_char   = chars_q[0];
	assign burst_take = burst_valid && ((rem_q == 3'd0) || (run_last && out_ready));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= 3'd0;
		end else if (burst_take) begin
			rem_q <= burst.count;
		end else if (out_valid && out_ready) begin
			rem_q <= rem_q - 3'd1;
		end
	end

	// advance one character per output transfer
	always_ff @(posedge clk) begin
		if (burst_take) begin
			chars_q <= burst.chars;
			fin_q   <= burst.fin;
		end else if (out_valid && out_ready) begin
			chars_q <= {8'h00, chars_q[MAX_CHARS-1:1]};
		end
	end

endmodule

`default_nettype wire

// ===== sv/base64_stream_encoder.sv =====
// Base64 encoder, one message byte per input transfer and one character per
// output transfer. encoding_mode (cfg_we/cfg_wdata) selects standard padded
// (0, and also 3), MIME with CR LF before a group once the line holds 76 or
// more characters (1), or URL-safe without padding (2); write it only while
// the block is idle. final_byte closes the message: the partial group is
// completed, padded where the mode pads, and text_end marks its last
// character. run_last marks the last character caused by each byte. A byte
// yields one to six characters, which leave at one per cycle while out_ready is
// high, so throughput is set by the character output; line breaks and padding
// add characters. A byte is registered in the input register, then its
// characters are built and loaded into the output buffer once it takes them;
// the next byte can enter the input register while the previous byte's characters leave.
`default_nettype none

module base64_stream_encoder import b64e_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [1:0] cfg_wdata,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] data_byte,
	input  wire logic       final_byte,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      out_char,
	output logic            run_last,
	output logic            text_end
);

	logic [1:0] mode_q;
	logic       burst_valid;
	logic       burst_take;
	burst_t     burst;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_STD;
		end else if (cfg_we) begin
			mode_q <= cfg_wdata;
		end
	end

	b64e_group_enc u_group_enc (
		.clk         (clk),
		.arst_n      (arst_n),
		.mode        (mode_q),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.data_byte   (data_byte),
		.final_byte  (final_byte),
		.burst_valid (burst_valid),
		.burst       (burst),
		.burst_take  (burst_take)
	);

	b64e_char_buf u_char_buf (
		.clk         (clk),
		.arst_n      (arst_n),
		.burst_valid (burst_valid),
		.burst       (burst),
		.burst_take  (burst_take),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_char    (out_char),
		.run_last    (run_last),
		.text_end    (text_end)
	);

	a_stall_has_output: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with no character pending");

	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !run_last) |=> out_valid)
		else $error("character run ended without run_last");

	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && text_end) |-> run_last)
		else $error("text_end without run_last");

endmodule

`default_nettype wire
